// ===== hw/rtl/agab_pkg.sv =====
package agab_pkg;

  localparam int BAND_DEF    = 16;
  localparam int SYMBOLS_DEF = 32;

  localparam logic [1:0] CMD_SCORE  = 2'd0;
  localparam logic [1:0] CMD_ROW    = 2'd1;
  localparam logic [1:0] CMD_CORNER = 2'd2;
  localparam logic [1:0] CMD_COLUMN = 2'd3;

  localparam logic [1:0] REG_GAP_EXTEND = 2'd0;
  localparam logic [1:0] REG_GAP_OPEN   = 2'd1;
  localparam logic [1:0] REG_LOCAL_MODE = 2'd2;

  localparam logic [3:0]  BOTTOM_ROW   = 4'd15;
  localparam logic [31:0] BEST_INIT    = 32'hFFFF_FFFF;
  localparam logic [15:0] EXTEND_RESET = 16'd1;
  localparam logic [15:0] OPEN_RESET   = 16'd10;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] u;
    logic [31:0] s;
  } nd_t;

  // data handed from one cell to the next
  typedef struct packed {
    nd_t         up;
    logic [31:0] diag;
    logic [31:0] best;
  } link_t;

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    smax = ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/agab_if.sv =====
interface agab_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [4:0]         query_symbol;
  logic [4:0]         subject_symbol;
  logic [3:0]         row_index;
  logic signed [7:0]  score_value;
  logic signed [31:0] node_t;
  logic signed [31:0] node_u;
  logic signed [31:0] node_s;
  logic               final_column;
  logic               start_job;
  modport source(output valid, command, query_symbol, subject_symbol, row_index,
                 score_value, node_t, node_u, node_s, final_column, start_job,
                 input ready);
  modport sink(input valid, command, query_symbol, subject_symbol, row_index,
               score_value, node_t, node_u, node_s, final_column, start_job,
               output ready);
endinterface

interface agab_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         out_row;
  logic signed [31:0] out_t;
  logic signed [31:0] out_u;
  logic signed [31:0] out_s;
  logic signed [31:0] best_score;
  logic               last;
  modport source(output valid, kind, out_row, out_t, out_u, out_s, best_score, last,
                 input ready);
  modport sink(input valid, kind, out_row, out_t, out_u, out_s, best_score, last,
               output ready);
endinterface

// ===== hw/rtl/agab_cell.sv =====
module agab_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 ld,
  input  agab_pkg::nd_t        ld_node,
  input  logic [4:0]           ld_subj,
  input  logic [31:0]          ext,
  input  logic [31:0]          open,
  input  logic                 local_mode,
  input  logic [31:0]          score,
  input  agab_pkg::link_t      link_in,
  output agab_pkg::link_t      link_out,
  output agab_pkg::nd_t        left,
  output logic [4:0]           subj
);
  import agab_pkg::*;

  nd_t         left_r;
  logic [4:0]  subj_r;
  link_t       link_r;
  nd_t         fresh;
  logic [31:0] s_raw;
  logic [31:0] best_nxt;

  always_comb begin
    fresh.t  = smax(left_r.t - ext, left_r.s - open);
    fresh.u  = smax(link_in.up.u - ext, link_in.up.s - open);
    s_raw    = smax(smax(link_in.diag + score, fresh.t), fresh.u);
    fresh.s  = local_mode ? smax(32'd0, s_raw) : s_raw;
    best_nxt = local_mode ? smax(link_in.best, fresh.s) : link_in.best;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      left_r <= ld_node;
      subj_r <= ld_subj;
    end else if (en) begin
      left_r <= fresh;
      link_r <= '{up: fresh, diag: left_r.s, best: best_nxt};
    end
  end

  assign link_out = link_r;
  assign left     = left_r;
  assign subj     = subj_r;
endmodule

// ===== hw/rtl/affine_gap_alignment_band_core.sv =====
// affine-gap alignment band core
// in_ch takes requests: score entry, band row load, corner load, column.
// loads give no result. a column flows through a chain of BAND cells, one
// row per cycle behind a registered score table read.
// a column gives its bottom node; a final column then gives the BAND
// right-edge nodes, rows 0 to BAND-1, one per cycle while out_ch is ready.
// the cell chain, the single score table read port and the results a column
// gives set how long it takes. in_ch.ready is high in idle.
// the output register lets a new request in while the last result waits.
// when out_ch stalls, results hold and the core waits.
// registers sit at byte addresses 0, 4, 8 on the psel/penable port; pready is
// always high. reset sets gap_extend 1, gap_open 10, local mode, best -1;
// score table, band and corner are undefined until loaded.
module affine_gap_alignment_band_core #(
  parameter int BAND    = agab_pkg::BAND_DEF,
  parameter int SYMBOLS = agab_pkg::SYMBOLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  agab_in_if.sink           in_ch,
  agab_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import agab_pkg::*;

  localparam int RW = $clog2(BAND);
  localparam int CW = $clog2(BAND + 2);
  localparam int EW = $clog2(BAND + 1);
  localparam int AW = $clog2(SYMBOLS * SYMBOLS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t      state_r;
  logic [15:0] ext_r, open_r;
  logic        local_r;
  logic [31:0] best_r;
  nd_t         corner_r, up0_r;
  logic [31:0] diag0_r;
  logic [4:0]  q_r;
  logic        final_r;
  logic [CW-1:0] cnt_r;
  logic [EW-1:0] e_r;
  logic [7:0]  mem [SYMBOLS*SYMBOLS];
  logic [7:0]  score_rd_r;
  logic        sym_ok_r;
  logic        out_valid_r, kind_r, last_r;
  logic [3:0]  row_r;
  nd_t         onode_r;
  logic [31:0] obest_r;

  logic        in_fire, wr_en;
  nd_t         bnode;
  logic [31:0] ext32, open32, score32;
  link_t       link  [BAND];
  link_t       lin   [BAND];
  nd_t         lefts [BAND];
  logic [4:0]  subjs [BAND];
  logic [4:0]  cur_subj;
  logic        out_free;
  nd_t         emit_node;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign in_fire = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign bnode   = '{t: in_ch.node_t, u: in_ch.node_u, s: in_ch.node_s};
  assign ext32   = {16'd0, ext_r};
  assign open32  = {16'd0, open_r} + {16'd0, ext_r};
  assign score32 = sym_ok_r ? {{24{score_rd_r[7]}}, score_rd_r} : 32'd0;
  assign cur_subj = subjs[cnt_r[RW-1:0]];
  assign out_free = ~out_valid_r | out_ch.ready;
  assign emit_node = (e_r == '0) ? lefts[BAND-1] : lefts[RW'(e_r - EW'(1))];

  always_comb begin
    case (paddr[3:2])
      REG_GAP_EXTEND: prdata = {16'd0, ext_r};
      REG_GAP_OPEN:   prdata = {16'd0, open_r};
      REG_LOCAL_MODE: prdata = {31'd0, local_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r   <= EXTEND_RESET;
      open_r  <= OPEN_RESET;
      local_r <= 1'b1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GAP_EXTEND: ext_r   <= pwdata[15:0];
        REG_GAP_OPEN:   open_r  <= pwdata[15:0];
        REG_LOCAL_MODE: local_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // score table
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == CMD_SCORE && int'(in_ch.query_symbol) < SYMBOLS
        && int'(in_ch.subject_symbol) < SYMBOLS) begin
      mem[AW'(AW'(in_ch.query_symbol) * AW'(SYMBOLS) + AW'(in_ch.subject_symbol))]
        <= in_ch.score_value;
    end
    score_rd_r <= mem[AW'(AW'(q_r) * AW'(SYMBOLS) + AW'(cur_subj))];
    sym_ok_r   <= (int'(q_r) < SYMBOLS) && (int'(cur_subj) < SYMBOLS);
  end

  genvar r;
  generate
    for (r = 0; r < BAND; r++) begin : g_cell
      if (r == 0) begin : g_head
        assign lin[r] = '{up: up0_r, diag: diag0_r, best: best_r};
      end else begin : g_body
        assign lin[r] = link[r-1];
      end
      agab_cell u_cell (
        .clk       (clk),
        .en        (state_r == ST_CALC && cnt_r == CW'(r + 1)),
        .ld        (in_fire && in_ch.command == CMD_ROW && in_ch.row_index == 4'(r)),
        .ld_node   (bnode),
        .ld_subj   (in_ch.subject_symbol),
        .ext       (ext32),
        .open      (open32),
        .local_mode(local_r),
        .score     (score32),
        .link_in   (lin[r]),
        .link_out  (link[r]),
        .left      (lefts[r]),
        .subj      (subjs[r])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == CMD_CORNER) begin
      corner_r <= bnode;
    end else if (in_fire && in_ch.command == CMD_COLUMN) begin
      corner_r <= bnode;
      up0_r    <= bnode;
      diag0_r  <= corner_r.s;
      q_r      <= in_ch.query_symbol;
      final_r  <= in_ch.final_column;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      best_r      <= BEST_INIT;
      cnt_r       <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != ST_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire && in_ch.command == CMD_CORNER && in_ch.start_job) best_r <= BEST_INIT;
          if (in_fire && in_ch.command == CMD_COLUMN) begin
            cnt_r   <= '0;
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(BAND + 1)) begin
            best_r  <= link[BAND-1].best;
            e_r     <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            kind_r      <= (e_r != '0);
            row_r       <= (e_r == '0) ? BOTTOM_ROW : 4'(e_r - EW'(1));
            onode_r     <= emit_node;
            obest_r     <= local_r ? best_r : 32'd0;
            last_r      <= (e_r == '0) ? ~final_r : (e_r == EW'(BAND));
            e_r         <= e_r + EW'(1);
            if ((e_r == '0 && !final_r) || e_r == EW'(BAND)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.out_row    = row_r;
  assign out_ch.out_t      = onode_r.t;
  assign out_ch.out_u      = onode_r.u;
  assign out_ch.out_s      = onode_r.s;
  assign out_ch.best_score = obest_r;
  assign out_ch.last       = last_r;

`ifndef SYNTHESIS
  a_best_floor: assert property (@(posedge clk) disable iff (!rst_n)
    $signed(best_r) >= -32'sd1) else $error("best below -1");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> cnt_r <= CW'(BAND + 1)) else $error("cnt overrun");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> e_r <= EW'(BAND)) else $error("emit overrun");
  a_calc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_CALC) |-> cnt_r == '0) else $error("calc entry");
`endif
endmodule

// ===== tb/affine_gap_alignment_band_core_tb.sv =====
`timescale 1ns / 1ps

module affine_gap_alignment_band_core_tb;
  import agab_pkg::*;

  localparam int NROWS = 16;
  localparam int NSYM = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] REG_NONE = 2'd3;
  // symbols that columns and band rows use; their table entries are all loaded
  localparam logic [4:0] SYM_SET [4] = '{5'd0, 5'd15, 5'd16, 5'd31};

  typedef struct {
    logic [1:0] cmd;
    logic [4:0] qsym;
    logic [4:0] ssym;
    logic [3:0] row;
    logic [7:0] sval;
    nd_t        bnode;
    logic       fin;
    logic       sj;
  } req_t;

  typedef struct {
    logic        kind;
    logic [3:0]  row;
    nd_t         n;
    logic [31:0] best;
    logic        last;
  } node_res_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  agab_in_if in_ch();
  agab_out_if out_ch();

  affine_gap_alignment_band_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [15:0] gap_ext_m, gap_open_m;
  logic        local_m;
  logic [7:0]  subst_m [NSYM][NSYM];
  logic [4:0]  subj_m [NROWS];
  nd_t         left_m [NROWS];
  nd_t         corner_m;
  logic [31:0] best_m;

  node_res_t nodes_due[$];
  int errors = 0;
  bit hold_out = 0;
  bit rx_calm = 0;
  bit tx_calm = 0;

  initial begin
    clk = 0;
    forever begin
      #5 clk = 1;
      #5 clk = 0;
    end
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] wider(logic [31:0] a, logic [31:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic void advance_column(req_t r);
    nd_t fresh [NROWS];
    nd_t up;
    nd_t c;
    logic [31:0] dg, ext, open, sc, bo;
    node_res_t e;
    ext = {16'd0, gap_ext_m};
    open = {16'd0, gap_open_m} + {16'd0, gap_ext_m};
    for (int i = 0; i < NROWS; i++) begin
      up = (i == 0) ? r.bnode : fresh[i-1];
      dg = (i == 0) ? corner_m.s : left_m[i-1].s;
      sc = {{24{subst_m[r.qsym][subj_m[i]][7]}}, subst_m[r.qsym][subj_m[i]]};
      c.t = wider(left_m[i].t - ext, left_m[i].s - open);
      c.u = wider(up.u - ext, up.s - open);
      c.s = wider(wider(dg + sc, c.t), c.u);
      if (local_m) begin
        c.s = wider(32'd0, c.s);
        best_m = wider(best_m, c.s);
      end
      fresh[i] = c;
    end
    for (int i = 0; i < NROWS; i++) left_m[i] = fresh[i];
    corner_m = r.bnode;
    bo = local_m ? best_m : 32'd0;
    e.kind = 1'b0; e.row = BOTTOM_ROW; e.n = fresh[NROWS-1]; e.best = bo; e.last = !r.fin;
    nodes_due.push_back(e);
    if (r.fin) begin
      for (int i = 0; i < NROWS; i++) begin
        e.kind = 1'b1; e.row = i[3:0]; e.n = fresh[i]; e.best = bo;
        e.last = (i == NROWS - 1);
        nodes_due.push_back(e);
      end
    end
  endfunction

  function automatic void apply_request(req_t r);
    case (r.cmd)
      CMD_SCORE: subst_m[r.qsym][r.ssym] = r.sval;
      CMD_ROW: begin
        subj_m[r.row] = r.ssym;
        left_m[r.row] = r.bnode;
      end
      CMD_CORNER: begin
        corner_m = r.bnode;
        if (r.sj) best_m = BEST_INIT;
      end
      default: advance_column(r);
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    node_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (nodes_due.size() == 0) begin
        flag_mismatch("unexpected node", out_ch.out_s, 32'd0);
      end else begin
        e = nodes_due.pop_front();
        if (out_ch.kind !== e.kind) flag_mismatch("kind", 32'(out_ch.kind), 32'(e.kind));
        if (out_ch.out_row !== e.row) flag_mismatch("row", 32'(out_ch.out_row), 32'(e.row));
        if (out_ch.out_t !== e.n.t) flag_mismatch("t", out_ch.out_t, e.n.t);
        if (out_ch.out_u !== e.n.u) flag_mismatch("u", out_ch.out_u, e.n.u);
        if (out_ch.out_s !== e.n.s) flag_mismatch("s", out_ch.out_s, e.n.s);
        if (out_ch.best_score !== e.best) flag_mismatch("best", out_ch.best_score, e.best);
        if (out_ch.last !== e.last) flag_mismatch("last", 32'(out_ch.last), 32'(e.last));
      end
    end
  end

  // result side
  initial begin
    int w;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 0;
      end
      w = rx_calm ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_request(req_t r);
    int w;
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    w = tx_calm ? 0 : $urandom_range(0, 19);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= r.cmd;
    in_ch.query_symbol <= r.qsym;
    in_ch.subject_symbol <= r.ssym;
    in_ch.row_index <= r.row;
    in_ch.score_value <= r.sval;
    in_ch.node_t <= r.bnode.t;
    in_ch.node_u <= r.bnode.u;
    in_ch.node_s <= r.bnode.s;
    in_ch.final_column <= r.fin;
    in_ch.start_job <= r.sj;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(r);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (nodes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAP_EXTEND: gap_ext_m = val[15:0];
      REG_GAP_OPEN: gap_open_m = val[15:0];
      REG_LOCAL_MODE: local_m = val[0];
      default: ;
    endcase
    want = (idx == REG_GAP_EXTEND) ? {16'd0, gap_ext_m} :
           (idx == REG_GAP_OPEN) ? {16'd0, gap_open_m} :
           (idx == REG_LOCAL_MODE) ? {31'd0, local_m} : 32'd0;
    @(posedge clk);
    if (prdata !== want) flag_mismatch("readback", prdata, want);
    if (pready !== 1'b1) flag_mismatch("pready", 32'(pready), 32'd1);
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h8000_0000 ^ $urandom_range(0, 3);
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic logic [4:0] pick_sym();
    return SYM_SET[$urandom_range(0, 3)];
  endfunction

  function automatic req_t make_req(logic [1:0] cmd);
    req_t r;
    r.cmd = cmd;
    r.qsym = (cmd == CMD_SCORE) ? 5'($urandom_range(0, 31)) : pick_sym();
    r.ssym = (cmd == CMD_SCORE) ? 5'($urandom_range(0, 31)) : pick_sym();
    r.row = 4'($urandom_range(0, 15));
    r.sval = 8'($urandom_range(0, 255));
    r.bnode.t = any_value();
    r.bnode.u = any_value();
    r.bnode.s = any_value();
    r.fin = ($urandom_range(0, 4) == 0);
    r.sj = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic req_t random_req();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return make_req(CMD_COLUMN);
    if (p < 75) return make_req(CMD_SCORE);
    if (p < 90) return make_req(CMD_ROW);
    return make_req(CMD_CORNER);
  endfunction

  function automatic req_t fixed_req(logic [1:0] cmd, logic [4:0] q, logic [4:0] sb,
                                     logic [3:0] row, logic [7:0] sv, logic [31:0] t,
                                     logic [31:0] u, logic [31:0] s, logic fin, logic sj);
    req_t r;
    r.cmd = cmd; r.qsym = q; r.ssym = sb; r.row = row; r.sval = sv;
    r.bnode.t = t; r.bnode.u = u; r.bnode.s = s; r.fin = fin; r.sj = sj;
    return r;
  endfunction

  initial begin
    req_t opening_reqs [$];
    static logic [15:0] ext_set [5] = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2};
    static logic [15:0] open_set [5] = '{16'd10, 16'd0, 16'hFFFF, 16'd7, 16'd5};
    static logic mode_set [5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_SCORE;
    in_ch.query_symbol <= '0; in_ch.subject_symbol <= '0; in_ch.row_index <= '0;
    in_ch.score_value <= '0; in_ch.node_t <= '0; in_ch.node_u <= '0; in_ch.node_s <= '0;
    in_ch.final_column <= 1'b0; in_ch.start_job <= 1'b0;
    gap_ext_m = EXTEND_RESET; gap_open_m = OPEN_RESET; local_m = 1'b1; best_m = BEST_INIT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every store before any column reads it
    foreach (SYM_SET[qi])
      foreach (SYM_SET[si])
        send_request(fixed_req(CMD_SCORE, SYM_SET[qi], SYM_SET[si], 4'd0,
                               8'($urandom_range(0, 255)), 0, 0, 0, 0, 0));
    for (int i = 0; i < NROWS; i++)
      send_request(fixed_req(CMD_ROW, 0, pick_sym(), 4'(i), 0,
                             any_value(), any_value(), any_value(), 0, 0));
    send_request(fixed_req(CMD_CORNER, 0, 0, 0, 0, 0, 0, 0, 0, 1));

    // extremes and every command
    opening_reqs.push_back(fixed_req(CMD_SCORE, 31, 31, 0, 8'h7F, 0, 0, 0, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_SCORE, 0, 0, 0, 8'h80, 0, 0, 0, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_SCORE, 31, 0, 0, 8'hFF, 0, 0, 0, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_ROW, 0, 31, 15, 0, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_ROW, 0, 0, 0, 0, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_CORNER, 31, 31, 15, 8'hFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0));
    opening_reqs.push_back(fixed_req(CMD_COLUMN, 31, 31, 15, 0, 32'h8000_0000,
                                     32'h8000_0000, 32'h8000_0000, 0, 0));
    opening_reqs.push_back(fixed_req(CMD_COLUMN, 0, 0, 0, 0, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1));
    opening_reqs.push_back(fixed_req(CMD_CORNER, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    opening_reqs.push_back(fixed_req(CMD_COLUMN, 31, 0, 0, 0, 0, 0, 0, 1, 0));
    opening_reqs.push_back(fixed_req(CMD_COLUMN, 15, 16, 5, 8'h55, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hFFFF_FFFF, 0, 1));
    foreach (opening_reqs[i]) send_request(opening_reqs[i]);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_GAP_EXTEND, {16'($urandom), ext_set[ph]});
      write_reg(REG_GAP_OPEN, {16'($urandom), open_set[ph]});
      write_reg(REG_LOCAL_MODE, {31'h0, mode_set[ph]});
      if (ph == 0) write_reg(REG_NONE, 32'hFFFF_FFFF);
      for (int k = 0; k < 26; k++) begin
        if (ph == 1 && k == 5) hold_out = 1;
        if (k == 20) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (nodes_due.size() != 0) @(posedge clk);
        end
        send_request(random_req());
      end
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/agab_pkg.sv
hw/rtl/agab_if.sv
hw/rtl/agab_cell.sv
hw/rtl/affine_gap_alignment_band_core.sv
tb/affine_gap_alignment_band_core_tb.sv
